>>> sv/scancode_line_editor_defines.svh
// ----------------------------------------------------------------------------
// Scancode line editor assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef SCANCODE_LINE_EDITOR_DEFINES_SVH
`define SCANCODE_LINE_EDITOR_DEFINES_SVH

// same-cycle implication
`define SLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/sle_pkg.sv
// ----------------------------------------------------------------------------
// Scancode line editor package
// Command type, scancode constants and the QWERTZ key tables.
// ----------------------------------------------------------------------------
`default_nettype none

package sle_pkg;

  localparam int LINE_MAX = 63;
  localparam int LINE_CAP = (LINE_MAX < 63) ? LINE_MAX : 63;
  localparam logic [5:0] LINE_CAP_W = 6'(LINE_CAP);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] SC_PREFIX     = 8'hE0;
  localparam logic [7:0] SC_LSHIFT     = 8'h2A;
  localparam logic [7:0] SC_RSHIFT     = 8'h36;
  localparam logic [7:0] SC_LSHIFT_BRK = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_BRK = 8'hB6;
  localparam logic [7:0] SC_ENTER      = 8'h1C;
  localparam logic [7:0] SC_BKSP       = 8'h0E;
  localparam logic [7:0] SC_LEFT       = 8'h4B;
  localparam logic [7:0] SC_RIGHT      = 8'h4D;
  localparam int         BREAK_BIT     = 7;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_EDIT   = 2'd1;
  localparam logic [1:0] KIND_SUBMIT = 2'd2;

  typedef enum logic [2:0] {
    OP_NOP    = 3'd0,
    OP_LEFT   = 3'd1,
    OP_RIGHT  = 3'd2,
    OP_BKSP   = 3'd3,
    OP_INSERT = 3'd4,
    OP_ENTER  = 3'd5
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
  } cmd_t;

  localparam logic [7:0] KEYS_PLAIN [64] = '{
    8'h00,8'h00,8'h31,8'h32,8'h33,8'h34,8'h35,8'h36,
    8'h37,8'h38,8'h39,8'h30,8'hDF,8'hB4,8'h08,8'h09,
    8'h71,8'h77,8'h65,8'h72,8'h74,8'h7A,8'h75,8'h69,
    8'h6F,8'h70,8'hFC,8'h2B,8'h0A,8'h00,8'h61,8'h73,
    8'h64,8'h66,8'h67,8'h68,8'h6A,8'h6B,8'h6C,8'hF6,
    8'hE4,8'h5E,8'h00,8'h23,8'h79,8'h78,8'h63,8'h76,
    8'h62,8'h6E,8'h6D,8'h2C,8'h2E,8'h2D,8'h00,8'h2A,
    8'h00,8'h20,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00
  };

  localparam logic [7:0] KEYS_SHIFTED [64] = '{
    8'h00,8'h00,8'h21,8'h22,8'hA7,8'h24,8'h25,8'h26,
    8'h2F,8'h28,8'h29,8'h3D,8'h3F,8'h60,8'h08,8'h09,
    8'h51,8'h57,8'h45,8'h52,8'h54,8'h5A,8'h55,8'h49,
    8'h4F,8'h50,8'hDC,8'h2A,8'h0A,8'h00,8'h41,8'h53,
    8'h44,8'h46,8'h47,8'h48,8'h4A,8'h4B,8'h4C,8'hD6,
    8'hC4,8'hB0,8'h00,8'h27,8'h59,8'h58,8'h43,8'h56,
    8'h42,8'h4E,8'h4D,8'h3B,8'h3A,8'h5F,8'h00,8'h2A,
    8'h00,8'h20,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00
  };

endpackage

`default_nettype wire

>>> sv/sle_front.sv
// ----------------------------------------------------------------------------
// Scancode front end
// Tracks shift and extended prefix, and turns each scancode into a command.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_front import sle_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // scancode[7:0]
  input  wire logic [0:0] s_tuser,   // focused[0]
  output logic            cmd_valid,
  input  wire logic       cmd_ready,
  output cmd_t            cmd
);

  logic shift_held, shift_held_next;
  logic prefix_seen, prefix_seen_next;
  logic [7:0] key_ch;
  logic focused;

  assign focused   = s_tuser[0];
  assign s_tready  = cmd_ready;
  assign cmd_valid = s_tvalid;

  always_comb begin
    key_ch = 8'h00;
    if (s_tdata[7:6] == 2'b00) begin
      key_ch = shift_held ? KEYS_SHIFTED[s_tdata[5:0]] : KEYS_PLAIN[s_tdata[5:0]];
    end
  end

  always_comb begin
    shift_held_next  = shift_held;
    prefix_seen_next = prefix_seen;
    cmd.op = OP_NOP;
    cmd.ch = key_ch;
    if (s_tdata == SC_PREFIX) begin
      prefix_seen_next = 1'b1;
    end else if (prefix_seen) begin
      prefix_seen_next = 1'b0;
      if (focused && !s_tdata[BREAK_BIT]) begin
        if (s_tdata == SC_LEFT) begin
          cmd.op = OP_LEFT;
        end else if (s_tdata == SC_RIGHT) begin
          cmd.op = OP_RIGHT;
        end
      end
    end else if (s_tdata == SC_LSHIFT || s_tdata == SC_RSHIFT) begin
      shift_held_next = 1'b1;
    end else if (s_tdata == SC_LSHIFT_BRK || s_tdata == SC_RSHIFT_BRK) begin
      shift_held_next = 1'b0;
    end else if (s_tdata[BREAK_BIT] || !focused) begin
      cmd.op = OP_NOP;
    end else if (s_tdata == SC_ENTER) begin
      cmd.op = OP_ENTER;
    end else if (s_tdata == SC_BKSP) begin
      cmd.op = OP_BKSP;
    end else if (key_ch != 8'h00) begin
      cmd.op = OP_INSERT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_held  <= 1'b0;
      prefix_seen <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      shift_held  <= shift_held_next;
      prefix_seen <= prefix_seen_next;
    end
  end

endmodule

`default_nettype wire

>>> sv/sle_queue.sv
// ----------------------------------------------------------------------------
// Command queue
// Small FIFO between the front end and the line engine.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_queue import sle_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_valid,
  output logic      wr_ready,
  input  cmd_t      wr_cmd,
  output logic      rd_valid,
  input  wire logic rd_ready,
  output cmd_t      rd_cmd
);

  cmd_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push, pop;

  assign wr_ready = (count != QCNT_W'(QDEPTH));
  assign rd_valid = (count != '0);
  assign rd_cmd   = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> sv/sle_back.sv
// ----------------------------------------------------------------------------
// Line engine
// Holds the line store, cursor and length; executes commands and emits results.
// ----------------------------------------------------------------------------
`default_nettype none

module sle_back import sle_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  output logic      cmd_ready,
  input  cmd_t      cmd,
  output logic        m_tvalid,
  input  wire logic   m_tready,
  output logic [23:0] m_tdata,   // char_out[7:0], cursor_pos[13:8], line_length[19:14], 0
  output logic [1:0]  m_tuser,   // kind[1:0]
  output logic        m_tlast    // last
);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_SHIFT  = 8'b0000_0010,
    ST_DRAIN  = 8'b0000_0100,
    ST_PUT    = 8'b0000_1000,
    ST_EMIT   = 8'b0001_0000,
    ST_ENT_RD = 8'b0010_0000,
    ST_ENT_LD = 8'b0100_0000,
    ST_ENT_NL = 8'b1000_0000
  } state_t;

  state_t     state;
  logic [7:0] line_store [64];
  logic [7:0] rdata;
  logic [5:0] cur, len, ptr, cnt, pend_addr, put_addr;
  logic       dir_ins, pend;
  logic [1:0] res_kind;
  logic [7:0] res_ch;
  logic       mem_we;
  logic [5:0] mem_wa;
  logic [7:0] mem_wd;
  logic       out_free;

  assign cmd_ready = (state == ST_IDLE);
  assign out_free  = !m_tvalid || m_tready;

  assign mem_we = pend || (state == ST_PUT);
  assign mem_wa = pend ? pend_addr : put_addr;
  assign mem_wd = pend ? rdata : res_ch;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_store[mem_wa] <= mem_wd;
    end
    rdata <= line_store[ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cur      <= '0;
      len      <= '0;
      pend     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            res_kind <= KIND_NONE;
            res_ch   <= 8'h00;
            state    <= ST_EMIT;
            case (cmd.op)
              OP_LEFT: begin
                if (cur != '0) begin
                  cur      <= cur - 1'b1;
                  res_kind <= KIND_EDIT;
                end
              end
              OP_RIGHT: begin
                if (cur < len) begin
                  cur      <= cur + 1'b1;
                  res_kind <= KIND_EDIT;
                end
              end
              OP_BKSP: begin
                if (cur != '0) begin
                  ptr      <= cur;
                  cnt      <= len - cur;
                  dir_ins  <= 1'b0;
                  cur      <= cur - 1'b1;
                  len      <= len - 1'b1;
                  res_kind <= KIND_EDIT;
                  state    <= (len == cur) ? ST_EMIT : ST_SHIFT;
                end
              end
              OP_INSERT: begin
                if (len < LINE_CAP_W) begin
                  ptr      <= len - 1'b1;
                  cnt      <= len - cur;
                  dir_ins  <= 1'b1;
                  put_addr <= cur;
                  cur      <= cur + 1'b1;
                  len      <= len + 1'b1;
                  res_kind <= KIND_EDIT;
                  res_ch   <= cmd.ch;
                  state    <= (len == cur) ? ST_PUT : ST_SHIFT;
                end
              end
              OP_ENTER: begin
                ptr   <= '0;
                cnt   <= len;
                cur   <= '0;
                len   <= '0;
                state <= (len == '0) ? ST_ENT_NL : ST_ENT_RD;
              end
              default: begin
                state <= ST_EMIT;
              end
            endcase
          end
        end
        ST_SHIFT: begin
          pend      <= 1'b1;
          pend_addr <= dir_ins ? ptr + 1'b1 : ptr - 1'b1;
          ptr       <= dir_ins ? ptr - 1'b1 : ptr + 1'b1;
          cnt       <= cnt - 1'b1;
          if (cnt == 6'd1) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          pend  <= 1'b0;
          state <= dir_ins ? ST_PUT : ST_EMIT;
        end
        ST_PUT: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_kind;
            m_tdata  <= {4'h0, len, cur, res_ch};
            m_tlast  <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        ST_ENT_RD: begin
          state <= ST_ENT_LD;
        end
        ST_ENT_LD: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tuser  <= KIND_SUBMIT;
            m_tdata  <= {16'h0000, rdata};
            m_tlast  <= 1'b0;
            ptr      <= ptr + 1'b1;
            cnt      <= cnt - 1'b1;
            state    <= (cnt == 6'd1) ? ST_ENT_NL : ST_ENT_RD;
          end
        end
        ST_ENT_NL: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tuser  <= KIND_SUBMIT;
            m_tdata  <= {16'h0000, CH_NEWLINE};
            m_tlast  <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> sv/scancode_line_editor.sv
// ----------------------------------------------------------------------------
// Scancode line editor
// Set-1 scancode decoder (German QWERTZ) with an editable 63-character line.
// ----------------------------------------------------------------------------
// One scancode per input transaction, focus flag in tuser. Every input gives
// at least one result transaction; enter gives one per line character and a
// newline, tlast on the final one. Items are worked one at a time by the line
// engine behind a four-entry command queue; a command passes through the queue
// and the engine state before its first result is registered on the output. An
// insert or a backspace away from the line end shifts the line store, which
// moves one entry per cycle through its single write port. Enter reads each
// character through the registered read of the line store before sending it. A
// stalled result stream holds the engine. The line store needs no clearing pass
// after reset.
`default_nettype none

module scancode_line_editor import sle_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // scancode[7:0]
  input  wire logic [0:0]  s_tuser,   // focused[0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // char_out[7:0], cursor_pos[13:8], line_length[19:14], 0
  output logic [1:0]       m_tuser,   // kind[1:0]
  output logic             m_tlast    // last
);

  logic f_valid, f_ready;
  cmd_t f_cmd;
  logic q_valid, q_ready;
  cmd_t q_cmd;

  sle_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  sle_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_cmd   (f_cmd),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_cmd   (q_cmd)
  );

  sle_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

`default_nettype wire

>>> sv/sle_checker.sv
// ----------------------------------------------------------------------------
// Scancode line editor checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "scancode_line_editor_defines.svh"

module sle_checker import sle_pkg::*; (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [23:0] m_tdata,
  input wire logic [1:0]  m_tuser,
  input wire logic        m_tlast
);

  `SLE_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")
  `SLE_ASSERT_NOW(a_kind, m_tvalid, m_tuser != 2'd3, "undefined result kind")
  `SLE_ASSERT_NOW(a_cursor, m_tvalid, m_tdata[13:8] <= m_tdata[19:14], "cursor beyond line end")
  `SLE_ASSERT_NOW(a_submit, m_tvalid && m_tuser == KIND_SUBMIT, m_tdata[19:8] == 12'h000, "submitted line not cleared")
  `SLE_ASSERT_NOW(a_single, m_tvalid && m_tuser != KIND_SUBMIT, m_tlast, "edit result not last")

endmodule

bind scancode_line_editor sle_checker u_sle_checker (.*);

`default_nettype wire
